// ===== hdl/ppfu_pkg.sv =====
package ppfu_pkg;

    localparam int MaxParticles = 4096;
    localparam int SlotW        = $clog2(MaxParticles);
    localparam int SlotRamW     = 112;

    localparam logic [31:0] LcgMul  = 32'd1664525;
    localparam logic [31:0] LcgAdd  = 32'd1013904223;
    localparam logic [31:0] LcgInit = 32'h00C0FFEE;
    localparam logic [15:0] SpeedBase = 16'd26214;
    localparam logic [13:0] SpeedSpan = 14'd13107;

    localparam logic [2:0] RegHalfExtent   = 3'd0;
    localparam logic [2:0] RegColumnHeight = 3'd1;
    localparam logic [2:0] RegRainCap      = 3'd2;
    localparam logic [2:0] RegSnowCap      = 3'd3;
    localparam logic [2:0] RegRainFall     = 3'd4;
    localparam logic [2:0] RegSnowFall     = 3'd5;
    localparam logic [2:0] RegRngSeed      = 3'd6;

    localparam logic [1:0] KindNone  = 2'd0;
    localparam logic [1:0] KindRain  = 2'd1;
    localparam logic [1:0] KindSnow  = 2'd2;
    localparam logic [1:0] KindSpare = 2'd3;

    localparam logic CmdInit = 1'b0;
    localparam logic CmdTick = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_EASE_MUL,
        S_EASE_APPLY,
        S_LIVE_MUL1,
        S_LIVE_MUL2,
        S_LIVE_SET,
        S_DRIFT,
        S_INIT_SLOT,
        S_DRAW,
        S_DRAW_USE,
        S_DRAW_MUL,
        S_SLOT_WRITE,
        S_READ,
        S_FALL_MUL1,
        S_FALL_MUL2,
        S_MOVE,
        S_WRAP,
        S_TICK_WRITE,
        S_DONE
    } t_state;

    function automatic logic [31:0] lcg_next(input logic [31:0] w);
        lcg_next = w * LcgMul + LcgAdd;
    endfunction

endpackage

// ===== hdl/ppfu_slot_ram.sv =====
module ppfu_slot_ram #(
    parameter int Depth = 4096,
    parameter int Width = 112
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/precipitation_particle_field_update.sv =====
// precipitation particle field update
//
// input channel (i_in_valid / o_in_ready) takes one command item: an init
// scatter (cmd 0) or a frame tick (cmd 1). output channel (o_out_valid /
// i_out_ready) returns one result item per command: live count, eased sky
// level and respawn count.
// configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
// the user must write it only while the block is idle, which the block
// itself does not enforce. particle slots live in one single-port-write,
// one-read RAM with a registered read; each slot is handled in turn by one
// shared multiplier sequencer, so one item at a time is in flight.
// init: six random draws per slot. tick: each live slot is read, moved,
// wrapped and written back, or respawned if it fell below zero height.
// ticks with no precipitation or a zero delta time skip the slot pass.
// reset (synchronous, active low) restores the register defaults, the
// generator word, sky level and counts; slot contents stay undefined until
// the first init. a finished result sits in an output register; when the
// receiver stalls the block holds it and takes no new item until it goes.

module precipitation_particle_field_update (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [15:0] i_delta_time,
    input  logic [1:0]  i_weather_kind,
    input  logic [16:0] i_strength,
    input  logic signed [15:0] i_wind_east,
    input  logic signed [15:0] i_wind_north,
    input  logic [16:0] i_sky_open,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [12:0] o_live_count,
    output logic [16:0] o_sky_level,
    output logic [12:0] o_respawn_count
);
    import ppfu_pkg::*;

    logic [24:0] r_half_extent, r_column_height;
    logic [12:0] r_rain_cap, r_snow_cap;
    logic [15:0] r_rain_fall, r_snow_fall;
    logic [31:0] r_rng_seed;

    logic [31:0] r_rng;
    logic [16:0] r_sky;
    logic [12:0] r_active, r_pool;

    t_state r_state, n_state;

    logic        r_cmd;
    logic [15:0] r_dt;
    logic [1:0]  r_kind;
    logic [16:0] r_strength, r_target;
    logic signed [15:0] r_we_wind, r_wn_wind;

    logic [SlotW-1:0] r_idx;
    logic [12:0] r_respawn;
    logic [2:0]  r_draw_no;
    logic        r_at_top;
    logic [63:0] r_prod;
    logic [16:0] r_k;
    logic [31:0] r_dx, r_dz;
    logic [31:0] r_px, r_pz, r_ph;
    logic [15:0] r_sf;
    logic [23:0] r_u;
    logic        r_out_valid;
    logic [12:0] r_out_live, r_out_resp;
    logic [16:0] r_out_sky;

    logic [SlotRamW-1:0] w_rdata;
    logic                w_we;
    logic [SlotRamW-1:0] w_wdata;

    ppfu_slot_ram #(.Depth(MaxParticles), .Width(SlotRamW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_idx),
        .i_wdata(w_wdata),
        .i_raddr(r_idx),
        .o_rdata(w_rdata)
    );

    assign w_we    = (r_state == S_SLOT_WRITE) || (r_state == S_TICK_WRITE);
    assign w_wdata = {r_px, r_pz, r_ph, r_sf};

    assign o_in_ready      = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_live_count    = r_out_live;
    assign o_sky_level     = r_out_sky;
    assign o_respawn_count = r_out_resp;

    logic        w_snow;
    logic [12:0] w_cap;
    logic [15:0] w_fall;
    logic [12:0] w_init_pool;
    logic        w_no_precip;
    logic [31:0] w_rng_next;
    logic signed [32:0] w_spread;
    logic [16:0] w_sky_diff;
    logic [12:0] w_last;
    logic [19:0] w_k_raw;
    logic signed [32:0] w_wind_dt_e, w_wind_dt_n;
    logic [31:0] w_new_ph;

    assign w_snow = (r_kind == KindSnow);
    assign w_cap  = w_snow ? r_snow_cap : r_rain_cap;
    assign w_fall = w_snow ? r_snow_fall : r_rain_fall;
    assign w_rng_next = lcg_next(r_rng);
    assign w_last = 13'(r_idx) + 13'd1;
    assign w_k_raw = ({4'b0, r_dt} * 20'd5) >> 1;
    assign w_wind_dt_e = r_we_wind * $signed({1'b0, r_dt});
    assign w_wind_dt_n = r_wn_wind * $signed({1'b0, r_dt});
    assign w_new_ph = r_ph - 32'(r_prod >> 23);

    always_comb begin
        w_init_pool = (r_rain_cap > r_snow_cap) ? r_rain_cap : r_snow_cap;
        if (w_init_pool > 13'(MaxParticles)) begin
            w_init_pool = 13'(MaxParticles);
        end
    end

    assign w_no_precip = (r_kind == KindNone) || (r_kind == KindSpare)
                         || (r_strength <= 17'd65) || (r_pool == '0);
    assign w_sky_diff  = (r_target >= r_sky) ? (r_target - r_sky) : (r_sky - r_target);

    // spread product truncated toward zero: r_prod holds signed (2u-2^24)*ext
    always_comb begin
        logic signed [63:0] p;
        logic signed [63:0] q;
        p = $signed(r_prod);
        q = (p + (p < 0 ? 64'sd16777215 : 64'sd0)) >>> 24;
        w_spread = 33'(q);
    end

    // wrap of the moved coordinate
    function automatic logic [31:0] wrap(input logic [31:0] p, input logic [24:0] e);
        logic signed [33:0] v;
        logic signed [33:0] ee;
        ee = 34'($signed({1'b0, e}));
        v  = 34'($signed(p));
        if (v > ee) begin
            v = 34'($signed(32'(v - 2 * ee)));
        end
        if (v < -ee) begin
            v = 34'($signed(32'(v + 2 * ee)));
        end
        wrap = v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_extent   <= 25'd1310720;
            r_column_height <= 25'd1966080;
            r_rain_cap      <= 13'd2048;
            r_snow_cap      <= 13'd2048;
            r_rain_fall     <= 16'd2304;
            r_snow_fall     <= 16'd282;
            r_rng_seed      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegHalfExtent:   r_half_extent   <= i_cfg_data[24:0];
                RegColumnHeight: r_column_height <= i_cfg_data[24:0];
                RegRainCap:      r_rain_cap      <= i_cfg_data[12:0];
                RegSnowCap:      r_snow_cap      <= i_cfg_data[12:0];
                RegRainFall:     r_rain_fall     <= i_cfg_data[15:0];
                RegSnowFall:     r_snow_fall     <= i_cfg_data[15:0];
                RegRngSeed:      r_rng_seed      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:       if (i_in_valid && o_in_ready) n_state = S_DECODE;
            S_DECODE: begin
                if (r_cmd == CmdInit) begin
                    n_state = (w_init_pool == '0) ? S_DONE : S_INIT_SLOT;
                end else if (w_no_precip || r_dt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_EASE_MUL;
                end
            end
            S_EASE_MUL:   n_state = S_EASE_APPLY;
            S_EASE_APPLY: n_state = S_LIVE_MUL1;
            S_LIVE_MUL1:  n_state = S_LIVE_MUL2;
            S_LIVE_MUL2:  n_state = S_LIVE_SET;
            S_LIVE_SET:   n_state = S_DRIFT;
            S_DRIFT:      n_state = (r_active == '0) ? S_DONE : S_READ;
            S_INIT_SLOT:  n_state = S_DRAW;
            S_DRAW:       n_state = S_DRAW_USE;
            S_DRAW_USE:   n_state = S_DRAW_MUL;
            S_DRAW_MUL:   n_state = (r_draw_no == 3'd5) ? S_SLOT_WRITE : S_DRAW;
            S_SLOT_WRITE: begin
                if (r_at_top) begin
                    n_state = (w_last == r_active) ? S_DONE : S_READ;
                end else begin
                    n_state = (w_last == r_pool) ? S_DONE : S_INIT_SLOT;
                end
            end
            S_READ:       n_state = S_FALL_MUL1;
            S_FALL_MUL1:  n_state = S_FALL_MUL2;
            S_FALL_MUL2:  n_state = S_MOVE;
            S_MOVE:       n_state = w_new_ph[31] ? S_DRAW : S_WRAP;
            S_WRAP:       n_state = S_TICK_WRITE;
            S_TICK_WRITE: n_state = (w_last == r_active) ? S_DONE : S_READ;
            S_DONE:       n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng       <= LcgInit;
            r_sky       <= '0;
            r_active    <= '0;
            r_pool      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state) inside
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_cmd      <= i_cmd;
                        r_dt       <= i_delta_time;
                        r_kind     <= i_weather_kind;
                        r_strength <= (i_strength > 17'd65536) ? 17'd65536 : i_strength;
                        r_target   <= (i_sky_open > 17'd65536) ? 17'd65536 : i_sky_open;
                        r_we_wind  <= i_wind_east;
                        r_wn_wind  <= i_wind_north;
                    end
                end
                S_DECODE: begin
                    r_idx     <= '0;
                    r_respawn <= '0;
                    if (r_cmd == CmdInit) begin
                        r_rng    <= (r_rng_seed != '0) ? r_rng_seed : LcgInit;
                        r_pool   <= w_init_pool;
                        r_active <= '0;
                        r_at_top <= 1'b0;
                    end else if (w_no_precip) begin
                        r_active <= '0;
                    end else begin
                        r_k <= (w_k_raw > 20'd65536) ? 17'd65536 : w_k_raw[16:0];
                        r_at_top <= 1'b1;
                    end
                end
                S_EASE_MUL: r_prod <= 64'(w_sky_diff) * 64'(r_k);
                S_EASE_APPLY: begin
                    if (r_target >= r_sky) begin
                        r_sky <= r_sky + 17'(r_prod >> 16);
                    end else begin
                        r_sky <= r_sky - 17'(r_prod >> 16);
                    end
                end
                S_LIVE_MUL1: r_prod <= 64'(w_cap) * 64'(r_strength);
                S_LIVE_MUL2: r_prod <= 64'(r_prod[29:0]) * 64'(r_sky);
                S_LIVE_SET: begin
                    if ((r_prod >> 32) > 64'(r_pool)) begin
                        r_active <= r_pool;
                    end else begin
                        r_active <= 13'(r_prod >> 32);
                    end
                end
                S_DRIFT: begin
                    r_dx <= 32'(w_wind_dt_e / 33'sd256);
                    r_dz <= 32'(w_wind_dt_n / 33'sd256);
                end
                S_INIT_SLOT: r_draw_no <= '0;
                S_DRAW: r_rng <= w_rng_next;
                S_DRAW_USE: begin
                    r_u <= r_rng[31:8];
                end
                S_DRAW_MUL: begin
                    unique case (r_draw_no) inside
                        3'd0, 3'd1:
                            r_prod <= 64'($signed({1'b0, r_u, 1'b0}) - 27'sd16777216)
                                      * 64'(r_half_extent);
                        3'd2:    r_prod <= 64'(r_u) * 64'(r_column_height);
                        3'd5:    r_sf <= SpeedBase + 16'((64'(r_u) * 64'(SpeedSpan)) >> 24);
                        default: ;
                    endcase
                    r_draw_no <= r_draw_no + ((r_at_top && r_draw_no == 3'd1) ? 3'd2 : 3'd1);
                end
                S_READ: ;
                S_FALL_MUL1: begin
                    {r_px, r_pz, r_ph, r_sf} <= w_rdata;
                    r_prod <= 64'(w_fall) * 64'(w_rdata[15:0]);
                end
                S_FALL_MUL2: r_prod <= 64'(r_prod[31:0]) * 64'(r_dt);
                S_MOVE: begin
                    r_ph <= w_new_ph;
                    r_px <= r_px + r_dx;
                    r_pz <= r_pz + r_dz;
                    if (w_new_ph[31]) begin
                        r_respawn <= r_respawn + 13'd1;
                        r_draw_no <= '0;
                    end
                end
                S_WRAP: begin
                    r_px <= wrap(r_px, r_half_extent);
                    r_pz <= wrap(r_pz, r_half_extent);
                end
                S_SLOT_WRITE, S_TICK_WRITE: r_idx <= r_idx + SlotW'(1);
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_out_live  <= r_active;
                    r_out_sky   <= r_sky;
                    r_out_resp  <= r_respawn;
                end
                default: ;
            endcase
            // spread results land in the S_DRAW state that follows their product
            if (r_state == S_DRAW && r_draw_no == 3'd1) r_px <= w_spread[31:0];
            if (r_state == S_DRAW && r_draw_no == 3'd2) r_pz <= w_spread[31:0];
            if (r_state == S_DRAW && r_draw_no == 3'd3 && !r_at_top) begin
                r_ph <= 32'(r_prod >> 24);
            end
            if (r_state == S_DRAW && r_draw_no == 3'd3 && r_at_top) begin
                r_pz <= w_spread[31:0];
            end
            if (r_state == S_DRAW_MUL && r_draw_no == 3'd5 && r_at_top) begin
                r_ph <= 32'(r_column_height);
            end
        end
    end

endmodule

// ===== hdl/ppfu_checker.sv =====
module ppfu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [12:0] o_live_count,
    input logic [16:0] o_sky_level,
    input logic [12:0] o_respawn_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_live_count))
        else $error("result dropped while stalled");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("item taken while result pending");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

    a_sky_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sky_level <= 17'd65536)
        else $error("sky level out of range");

    a_resp_le_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_respawn_count <= o_live_count)
        else $error("more respawns than live particles");

endmodule

bind precipitation_particle_field_update ppfu_checker u_ppfu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_live_count   (o_live_count),
    .o_sky_level    (o_sky_level),
    .o_respawn_count(o_respawn_count)
);
